// File: sv/sst_obe_pkg.sv
// Shared types and constants for the serial transport originator bit engine.
// Used by the top level and its port checker; depends on nothing else.
package sst_obe_pkg;

   // Command codes carried in the command field
   localparam logic [1:0] CMD_NONE  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;
   localparam logic [1:0] CMD_CLEAR = 2'd3;

   // Configuration register indexes
   localparam logic [1:0] CSR_BIT_TICKS       = 2'd0;
   localparam logic [1:0] CSR_HIGH_ONE_TICKS  = 2'd1;
   localparam logic [1:0] CSR_HIGH_ZERO_TICKS = 2'd2;
   localparam logic [1:0] CSR_CLEAR_TICKS     = 2'd3;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 24;
   localparam int TICK_W     = 24;
   localparam int TIME_W     = 16;

   // Reset values of the configuration registers
   localparam logic [TIME_W-1:0] BIT_TICKS_RST       = 16'd40;
   localparam logic [TIME_W-1:0] HIGH_ONE_TICKS_RST  = 16'd30;
   localparam logic [TIME_W-1:0] HIGH_ZERO_TICKS_RST = 16'd10;
   localparam logic [TICK_W-1:0] CLEAR_TICKS_RST     = 24'd100000;

   // Operation in progress
   typedef enum logic [3:0] {
      MODE_IDLE  = 4'b0001,
      MODE_WRITE = 4'b0010,
      MODE_READ  = 4'b0100,
      MODE_CLEAR = 4'b1000
   } mode_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] data_byte;
      logic       line_sense;
   } req_type;

   typedef struct packed {
      logic       line_level;
      logic       drive_strong;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
      logic       command_ignored;
   } rsp_type;

endpackage

// File: sv/sst_originator_bit_engine_top.sv
// A result word is registered and appears on rsp in the cycle after its tick word is accepted.
// Throughput: one tick word per cycle; req_ready drops only while a result is stalled.
// Per-tick timing is one pass of compare/increment logic against the tick counter.
// Reset (synchronous, active high): idle, bit position 7, counters and shifts zero,
// configuration registers back to 40/30/10/100000 ticks, no result pending.
// Depends on sst_obe_pkg.
module sst_originator_bit_engine_top
   import sst_obe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [TIME_W-1:0] bit_ticks_ff;
   logic [TIME_W-1:0] high_one_ff;
   logic [TIME_W-1:0] high_zero_ff;
   logic [TICK_W-1:0] clear_ticks_ff;

   mode_type          mode_ff, mode_in, mode_cur;
   logic [2:0]        pos_ff, pos_in, pos_cur;
   logic [TICK_W-1:0] tick_ff, tick_in, tick_cur;
   logic [7:0]        send_ff, send_in, send_cur;
   logic [7:0]        recv_ff, recv_in;

   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic              accept;

   logic [TICK_W:0]   tick_p1;
   logic [TIME_W-1:0] high_time;
   logic [TIME_W-1:0] half_time;
   logic [TICK_W:0]   read_end;
   logic [7:0]        sampled;
   logic              read_last;

   // Output register frees up when empty or being taken
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ticks_ff   <= BIT_TICKS_RST;
         high_one_ff    <= HIGH_ONE_TICKS_RST;
         high_zero_ff   <= HIGH_ZERO_TICKS_RST;
         clear_ticks_ff <= CLEAR_TICKS_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_BIT_TICKS:       bit_ticks_ff   <= csr_wdata[TIME_W-1:0];
            CSR_HIGH_ONE_TICKS:  high_one_ff    <= csr_wdata[TIME_W-1:0];
            CSR_HIGH_ZERO_TICKS: high_zero_ff   <= csr_wdata[TIME_W-1:0];
            CSR_CLEAR_TICKS:     clear_ticks_ff <= csr_wdata;
            default:             clear_ticks_ff <= clear_ticks_ff;
         endcase
      end
   end

   // Start a command when idle, then step the active operation by one tick
   always_comb begin
      mode_cur = mode_ff;
      pos_cur  = pos_ff;
      tick_cur = tick_ff;
      send_cur = send_ff;
      rsp_data_in = '0;
      rsp_data_in.drive_strong = 1'b1;

      if (mode_ff == MODE_IDLE) begin
         if (req_data.command != CMD_NONE) begin
            tick_cur = '0;
            pos_cur  = 3'd7;
            send_cur = '0;
            unique case (req_data.command)
               CMD_WRITE: begin
                  mode_cur = MODE_WRITE;
                  send_cur = req_data.data_byte;
               end
               CMD_READ:  mode_cur = MODE_READ;
               CMD_CLEAR: mode_cur = MODE_CLEAR;
               default:   mode_cur = MODE_IDLE;
            endcase
         end
      end else if (req_data.command != CMD_NONE) begin
         rsp_data_in.command_ignored = 1'b1;
      end

      tick_p1   = {1'b0, tick_cur} + {{TICK_W{1'b0}}, 1'b1};
      high_time = send_cur[7] ? high_one_ff : high_zero_ff;
      half_time = {1'b0, bit_ticks_ff[TIME_W-1:1]};
      read_end  = {{(TICK_W-TIME_W+1){1'b0}}, half_time}
                + {{(TICK_W-TIME_W){1'b0}}, high_zero_ff, 1'b0};
      sampled   = (tick_cur == {{(TICK_W-TIME_W){1'b0}}, half_time})
                ? {send_cur[6:0], req_data.line_sense} : send_cur;
      read_last = (tick_cur >= {{(TICK_W-TIME_W){1'b0}}, half_time})
                && (tick_p1 >= read_end);

      mode_in = mode_cur;
      pos_in  = pos_cur;
      tick_in = tick_p1[TICK_W-1:0];
      send_in = send_cur;
      recv_in = recv_ff;

      unique case (mode_cur)
         MODE_WRITE: begin
            rsp_data_in.busy_res   = 1'b1;
            rsp_data_in.line_level = tick_cur < {{(TICK_W-TIME_W){1'b0}}, high_time};
            if (tick_p1 >= {{(TICK_W-TIME_W+1){1'b0}}, bit_ticks_ff}) begin
               send_in = {send_cur[6:0], 1'b0};
               tick_in = '0;
               pos_in  = pos_cur - 3'd1;
               if (pos_cur == 3'd0) begin
                  rsp_data_in.done_res = 1'b1;
                  mode_in = MODE_IDLE;
               end
            end
         end
         MODE_READ: begin
            rsp_data_in.busy_res     = 1'b1;
            rsp_data_in.line_level   = 1'b1;
            rsp_data_in.drive_strong = (tick_cur == '0);
            send_in = sampled;
            if (read_last) begin
               tick_in = '0;
               pos_in  = pos_cur - 3'd1;
               if (pos_cur == 3'd0) begin
                  recv_in = sampled;
                  rsp_data_in.done_res = 1'b1;
                  mode_in = MODE_IDLE;
               end
            end
         end
         MODE_CLEAR: begin
            rsp_data_in.busy_res = 1'b1;
            if (tick_p1 >= {1'b0, clear_ticks_ff}) begin
               tick_in = '0;
               rsp_data_in.done_res = 1'b1;
               mode_in = MODE_IDLE;
            end
         end
         default: begin
            tick_in = tick_cur;
         end
      endcase

      rsp_data_in.read_data = recv_in;
   end

   // Advance the operation state once per accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         pos_ff  <= 3'd7;
         tick_ff <= '0;
         send_ff <= '0;
         recv_ff <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         pos_ff  <= pos_in;
         tick_ff <= tick_in;
         send_ff <= send_in;
         recv_ff <= recv_in;
      end
   end

   // Hold the result word until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// File: sv/sst_obe_checker.sv
// Port-level checker for the originator bit engine, bound to the top level.
// Depends on sst_obe_pkg and sst_originator_bit_engine_top.
module sst_obe_checker
   import sst_obe_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // No result pending right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // Completion and dropped commands only occur during an operation
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.done_res || rsp_data.command_ignored) |-> rsp_data.busy_res)
      else $error("done or ignore flagged while idle");

   // Idle ticks drive the line low and strong
   a_idle_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.busy_res |-> !rsp_data.line_level && rsp_data.drive_strong)
      else $error("line not driven low while idle");

   // Line is released only high, during a read
   a_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.drive_strong |-> rsp_data.line_level && rsp_data.busy_res)
      else $error("line released outside a read");

endmodule

bind sst_originator_bit_engine_top sst_obe_checker u_sst_obe_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
